// ----- design/c2va_pkg.sv -----
// ----------------------------------------------------------------------------
// c2va_pkg
// Shared types, constants and helpers for the conv2d valid-add block.
// ----------------------------------------------------------------------------
package c2va_pkg;

  localparam int IMAGE_MAX_DEF  = 64;
  localparam int FILTER_MAX_DEF = 8;

  localparam int IDX_W   = 12;
  localparam int DATA_W  = 32;
  localparam int IS_W    = 7;
  localparam int FS_W    = 4;
  localparam int BASE_W  = 2 * IS_W;
  localparam int WCNT_W  = 2 * FS_W;
  localparam int CFG_W   = 8;

  localparam int DIV_STEPS = 3;
  localparam int DIV_ITERS = IDX_W / DIV_STEPS;
  localparam int DIV_CNT_W = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] REQ_WEIGHT  = 2'd0;
  localparam logic [1:0] REQ_PIXEL   = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_SIZE  = 2'd2;

  localparam logic CFG_IMAGE_SIZE  = 1'b0;
  localparam logic CFG_FILTER_SIZE = 1'b1;

  typedef enum logic [1:0] {OP_WGT, OP_PIX, OP_CONV, OP_ERR} op_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   index;
    logic [DATA_W-1:0]  value;
    logic [1:0]         status;
    logic [BASE_W-1:0]  base;
  } job_t;

  typedef struct packed {
    logic [IS_W-1:0] img;
    logic [FS_W-1:0] flt;
    logic [IS_W-1:0] osz;
  } dims_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {F_IDLE, F_CHECK, F_DIV, F_BASE} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_MAC, B_DRAIN, B_OUT} back_state_t;

  // zero reads as one, anything above the maximum reads as the maximum
  function automatic logic [IS_W-1:0] clamp_size(input logic [IS_W-1:0] v,
                                                 input int unsigned maxv);
    logic [IS_W-1:0] r;
    if (v == '0) begin
      r = IS_W'(1);
    end else if (32'(v) > maxv) begin
      r = IS_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- design/c2va_front.sv -----
// ----------------------------------------------------------------------------
// c2va_front
// Takes requests, range-checks them and resolves the output row and column
// of a compute request into a window base address, then queues the job.
// ----------------------------------------------------------------------------
module c2va_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [1:0]                    req_type,
  input  logic [c2va_pkg::IDX_W-1:0]    index,
  input  logic signed [c2va_pkg::DATA_W-1:0] value,
  input  c2va_pkg::dims_t               dims,
  input  c2va_pkg::q_stat_t             q_stat,
  output logic                          q_push,
  output c2va_pkg::job_t                q_job
);

  c2va_pkg::front_state_t state, state_next;

  logic [1:0]                       kind;
  logic [c2va_pkg::IDX_W-1:0]       idx;
  logic [c2va_pkg::DATA_W-1:0]      val;
  logic [c2va_pkg::IDX_W-1:0]       dvd;
  logic [c2va_pkg::IS_W-1:0]        rem;
  logic [c2va_pkg::DIV_CNT_W-1:0]   cnt;

  logic [c2va_pkg::IDX_W-1:0]       dvd_step;
  logic [c2va_pkg::IS_W-1:0]        rem_step;
  logic [c2va_pkg::IDX_W-1:0]       d;
  logic [c2va_pkg::IS_W-1:0]        r;
  logic [c2va_pkg::IS_W:0]          t;

  logic [c2va_pkg::BASE_W-1:0]      idx_ext;
  logic [c2va_pkg::BASE_W-1:0]      flt_sq;
  logic [c2va_pkg::BASE_W-1:0]      img_sq;
  logic [c2va_pkg::BASE_W-1:0]      out_sq;
  logic [c2va_pkg::BASE_W-1:0]      base_val;

  logic                             chk_push;
  logic                             chk_div;
  c2va_pkg::job_t                   chk_job;

  assign idx_ext  = c2va_pkg::BASE_W'(idx);
  assign flt_sq   = c2va_pkg::BASE_W'(dims.flt) * c2va_pkg::BASE_W'(dims.flt);
  assign img_sq   = c2va_pkg::BASE_W'(dims.img) * c2va_pkg::BASE_W'(dims.img);
  assign out_sq   = c2va_pkg::BASE_W'(dims.osz) * c2va_pkg::BASE_W'(dims.osz);

  // quotient is below the output side, so its low bits are the whole row
  assign base_val = c2va_pkg::BASE_W'(dvd[c2va_pkg::IS_W-1:0])
                    * c2va_pkg::BASE_W'(dims.img) + c2va_pkg::BASE_W'(rem);

  assign item_stall = (state != c2va_pkg::F_IDLE);

  // classify the captured request
  always_comb begin
    chk_push       = 1'b0;
    chk_div        = 1'b0;
    chk_job.op     = c2va_pkg::OP_ERR;
    chk_job.index  = idx;
    chk_job.value  = val;
    chk_job.status = c2va_pkg::STAT_RANGE;
    chk_job.base   = '0;
    case (kind)
      c2va_pkg::REQ_WEIGHT: begin
        chk_push = 1'b1;
        if (idx_ext < flt_sq) begin
          chk_job.op     = c2va_pkg::OP_WGT;
          chk_job.status = c2va_pkg::STAT_OK;
        end
      end
      c2va_pkg::REQ_PIXEL: begin
        chk_push = 1'b1;
        if (idx_ext < img_sq) begin
          chk_job.op     = c2va_pkg::OP_PIX;
          chk_job.status = c2va_pkg::STAT_OK;
        end
      end
      c2va_pkg::REQ_COMPUTE: begin
        if (c2va_pkg::IS_W'(dims.flt) > dims.img) begin
          chk_push       = 1'b1;
          chk_job.status = c2va_pkg::STAT_SIZE;
        end else if (idx_ext >= out_sq) begin
          chk_push       = 1'b1;
        end else begin
          chk_div        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // restoring divide by the output side, a few quotient bits per cycle
  always_comb begin
    d = dvd;
    r = rem;
    t = '0;
    for (int k = 0; k < c2va_pkg::DIV_STEPS; k++) begin
      t = {r, d[c2va_pkg::IDX_W-1]};
      d = {d[c2va_pkg::IDX_W-2:0], 1'b0};
      if (t >= {1'b0, dims.osz}) begin
        t    = t - {1'b0, dims.osz};
        d[0] = 1'b1;
      end
      r = t[c2va_pkg::IS_W-1:0];
    end
    dvd_step = d;
    rem_step = r;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      c2va_pkg::F_IDLE: begin
        if (item_valid) state_next = c2va_pkg::F_CHECK;
      end
      c2va_pkg::F_CHECK: begin
        if (chk_div) begin
          state_next = c2va_pkg::F_DIV;
        end else if (!chk_push || !q_stat.full) begin
          state_next = c2va_pkg::F_IDLE;
        end
      end
      c2va_pkg::F_DIV: begin
        if (cnt == c2va_pkg::DIV_CNT_W'(c2va_pkg::DIV_ITERS - 1)) begin
          state_next = c2va_pkg::F_BASE;
        end
      end
      c2va_pkg::F_BASE: begin
        if (!q_stat.full) state_next = c2va_pkg::F_IDLE;
      end
      default: state_next = c2va_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    q_push = 1'b0;
    q_job  = chk_job;
    unique case (state)
      c2va_pkg::F_CHECK: q_push = chk_push && !q_stat.full;
      c2va_pkg::F_BASE: begin
        q_push       = !q_stat.full;
        q_job.op     = c2va_pkg::OP_CONV;
        q_job.status = c2va_pkg::STAT_OK;
        q_job.base   = base_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= c2va_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == c2va_pkg::F_IDLE && item_valid) begin
      kind <= req_type;
      idx  <= index;
      val  <= value;
      dvd  <= index;
      rem  <= '0;
      cnt  <= '0;
    end else if (state == c2va_pkg::F_DIV) begin
      dvd  <= dvd_step;
      rem  <= rem_step;
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

// ----- design/c2va_queue.sv -----
// ----------------------------------------------------------------------------
// c2va_queue
// Short job queue between the request front end and the compute back end.
// ----------------------------------------------------------------------------
module c2va_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  c2va_pkg::job_t    push_job,
  input  logic              pop,
  output c2va_pkg::job_t    head,
  output c2va_pkg::q_stat_t stat
);

  localparam int PTR_W = (c2va_pkg::QUEUE_DEPTH > 1) ? $clog2(c2va_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(c2va_pkg::QUEUE_DEPTH + 1);

  c2va_pkg::job_t      slots [c2va_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == CNT_W'(c2va_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(c2va_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(c2va_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/c2va_back.sv -----
// ----------------------------------------------------------------------------
// c2va_back
// Executes queued jobs: store writes, error replies and the window
// multiply-accumulate over the weight and image memories.
// ----------------------------------------------------------------------------
module c2va_back #(
  parameter int IMAGE_MAX  = c2va_pkg::IMAGE_MAX_DEF,
  parameter int FILTER_MAX = c2va_pkg::FILTER_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  c2va_pkg::dims_t                    dims,
  input  c2va_pkg::job_t                     head,
  input  c2va_pkg::q_stat_t                  q_stat,
  output logic                               q_pop,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [c2va_pkg::IDX_W-1:0]         out_index,
  output logic signed [c2va_pkg::DATA_W-1:0] out_value,
  output logic [1:0]                         status
);

  localparam int IMG_DEPTH = IMAGE_MAX * IMAGE_MAX;
  localparam int IA        = $clog2(IMG_DEPTH);
  localparam int WGT_DEPTH = FILTER_MAX * FILTER_MAX;
  localparam int WA        = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;

  c2va_pkg::back_state_t state, state_next;

  logic [c2va_pkg::DATA_W-1:0]  img_mem [IMG_DEPTH];
  logic [c2va_pkg::DATA_W-1:0]  wgt_mem [WGT_DEPTH];
  logic [c2va_pkg::DATA_W-1:0]  img_rd;
  logic [c2va_pkg::DATA_W-1:0]  wgt_rd;

  logic [c2va_pkg::IDX_W-1:0]   cur_index;
  logic [c2va_pkg::DATA_W-1:0]  acc;
  logic [c2va_pkg::DATA_W-1:0]  prod;
  logic [c2va_pkg::FS_W-1:0]    fr;
  logic [c2va_pkg::FS_W-1:0]    fc;
  logic [c2va_pkg::WCNT_W-1:0]  waddr;
  logic [c2va_pkg::BASE_W-1:0]  paddr;
  logic                         rd_v;
  logic                         rd_last;
  logic                         prod_v;
  logic                         prod_last;

  logic [c2va_pkg::FS_W-1:0]    fs_m1;
  logic                         mac_last;
  logic                         out_free;
  logic                         img_we;
  logic                         wgt_we;
  logic                         issue;
  logic                         conv_start;
  logic                         load_err;
  logic                         load_res;

  assign fs_m1    = dims.flt - 1'b1;
  assign mac_last = (fr == fs_m1) && (fc == fs_m1);
  assign out_free = !res_valid || !res_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      c2va_pkg::B_IDLE: begin
        if (!q_stat.empty && head.op == c2va_pkg::OP_CONV) state_next = c2va_pkg::B_MAC;
      end
      c2va_pkg::B_MAC: begin
        if (mac_last) state_next = c2va_pkg::B_DRAIN;
      end
      c2va_pkg::B_DRAIN: begin
        if (prod_v && prod_last) state_next = c2va_pkg::B_OUT;
      end
      c2va_pkg::B_OUT: begin
        if (out_free) state_next = c2va_pkg::B_IDLE;
      end
      default: state_next = c2va_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    img_we     = 1'b0;
    wgt_we     = 1'b0;
    issue      = 1'b0;
    conv_start = 1'b0;
    load_err   = 1'b0;
    load_res   = 1'b0;
    unique case (state)
      c2va_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          case (head.op)
            c2va_pkg::OP_WGT: begin
              wgt_we = 1'b1;
              q_pop  = 1'b1;
            end
            c2va_pkg::OP_PIX: begin
              img_we = 1'b1;
              q_pop  = 1'b1;
            end
            c2va_pkg::OP_CONV: begin
              conv_start = 1'b1;
              q_pop      = 1'b1;
            end
            c2va_pkg::OP_ERR: begin
              load_err = out_free;
              q_pop    = out_free;
            end
            default: ;
          endcase
        end
      end
      c2va_pkg::B_MAC: issue = 1'b1;
      c2va_pkg::B_OUT: load_res = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= c2va_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window walk: weights in order, image address jumps by the output side
  always_ff @(posedge clk) begin
    if (conv_start) begin
      cur_index <= head.index;
      fr        <= '0;
      fc        <= '0;
      waddr     <= '0;
      paddr     <= head.base;
    end else if (issue) begin
      waddr <= waddr + 1'b1;
      if (fc == fs_m1) begin
        fc    <= '0;
        fr    <= fr + 1'b1;
        paddr <= paddr + c2va_pkg::BASE_W'(dims.osz);
      end else begin
        fc    <= fc + 1'b1;
        paddr <= paddr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (img_we) img_mem[IA'(head.index)] <= head.value;
    img_rd <= img_mem[IA'(paddr)];
  end

  always_ff @(posedge clk) begin
    if (wgt_we) wgt_mem[WA'(head.index)] <= head.value;
    wgt_rd <= wgt_mem[WA'(waddr)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v      <= 1'b0;
      rd_last   <= 1'b0;
      prod_v    <= 1'b0;
      prod_last <= 1'b0;
    end else begin
      rd_v      <= issue;
      rd_last   <= issue && mac_last;
      prod_v    <= rd_v;
      prod_last <= rd_last;
    end
  end

  // accumulator starts at the add value
  always_ff @(posedge clk) begin
    prod <= img_rd * wgt_rd;
    if (conv_start) begin
      acc <= head.value;
    end else if (prod_v) begin
      acc <= acc + prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_err || load_res) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_err) begin
      out_index <= head.index;
      out_value <= '0;
      status    <= head.status;
    end else if (load_res) begin
      out_index <= cur_index;
      out_value <= acc;
      status    <= c2va_pkg::STAT_OK;
    end
  end

endmodule

// ----- design/conv2d_valid_add.sv -----
// ----------------------------------------------------------------------------
// conv2d_valid_add
// Valid 2D cross-correlation, stride 1, plus element-wise add, int32 wrap.
// ----------------------------------------------------------------------------
// Usage:
//   request channel (item_valid / item_stall): req_type selects weight load,
//   pixel load or compute; index is the row-major position, value the data
//   or the add value. Loads that are in range and requests of req_type 3 give
//   no result; every other request gives one result on the result channel
//   (res_valid / res_stall) with out_index, out_value and status.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) sets the
//   image side (index 0) and filter side (index 1); write it only when idle.
// Flow:
//   the front end holds a load or a rejected compute through its accept and
//   check states, and a compute also through the divider, which resolves row
//   and column, and the base state. The back end has one multiply-accumulate;
//   the job queue lets the front end take a new request while the back end
//   still works on earlier jobs.
// Reset: sizes go to 32 and 3; the stores keep no reset value and must be
//   written before they are read. A two-entry job queue links the two ends.
// A stalled result stays in the output register; the back end waits, the
//   queue fills, then item_stall holds off new requests.
// ----------------------------------------------------------------------------
module conv2d_valid_add #(
  parameter int IMAGE_MAX  = c2va_pkg::IMAGE_MAX_DEF,
  parameter int FILTER_MAX = c2va_pkg::FILTER_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic [1:0]                         req_type,
  input  logic [c2va_pkg::IDX_W-1:0]         index,
  input  logic signed [c2va_pkg::DATA_W-1:0] value,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [c2va_pkg::IDX_W-1:0]         out_index,
  output logic signed [c2va_pkg::DATA_W-1:0] out_value,
  output logic [1:0]                         status,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [c2va_pkg::CFG_W-1:0]         cfg_data
);

  logic [c2va_pkg::IS_W-1:0]  image_size;
  logic [c2va_pkg::FS_W-1:0]  filter_side;

  c2va_pkg::dims_t    dims;
  c2va_pkg::q_stat_t  q_stat;
  c2va_pkg::job_t     q_job;
  c2va_pkg::job_t     q_head;
  logic               q_push;
  logic               q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size  <= c2va_pkg::IS_W'(32);
      filter_side <= c2va_pkg::FS_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        c2va_pkg::CFG_IMAGE_SIZE:  image_size  <= cfg_data[c2va_pkg::IS_W-1:0];
        c2va_pkg::CFG_FILTER_SIZE: filter_side <= cfg_data[c2va_pkg::FS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dims.img = c2va_pkg::clamp_size(image_size, IMAGE_MAX);
    dims.flt = c2va_pkg::FS_W'(c2va_pkg::clamp_size(c2va_pkg::IS_W'(filter_side),
                                                    FILTER_MAX));
    // only meaningful when the filter fits the image
    dims.osz = dims.img - c2va_pkg::IS_W'(dims.flt) + 1'b1;
  end

  c2va_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .req_type   (req_type),
    .index      (index),
    .value      (value),
    .dims       (dims),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_job      (q_job)
  );

  c2va_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  c2va_back #(
    .IMAGE_MAX  (IMAGE_MAX),
    .FILTER_MAX (FILTER_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .dims      (dims),
    .head      (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_index (out_index),
    .out_value (out_value),
    .status    (status)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_stat.empty))
    else $error("job queue read while empty");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("front end took a request without going busy");

  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status != c2va_pkg::STAT_OK) |-> (out_value == '0))
    else $error("error result carries data");
`endif

endmodule
